// ----- rtl/core/kssc_pkg.sv -----
// Shared codes for the keyed session stack cache.
// Holds command, status and configuration index codes and field widths; no dependencies.
package kssc_pkg;

  // Input command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_COUNT = 2'd2;
  // Unassigned code, treated as a count
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_PER_KEY   = 2'd0;
  localparam logic [1:0] CFG_VALIDITY      = 2'd1;
  localparam logic [1:0] CFG_CLEANUP_DELAY = 2'd2;

  // Field widths fixed by the interface
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PORT_H_W = 16;
  localparam int unsigned TOTAL_W  = 8;

endpackage

// ----- rtl/core/keyed_session_stack_cache.sv -----
// Keyed session stack cache top level: slot table, scan sequencer, results.
// Depends on kssc_pkg and kssc_handle_ring.
//
//  Channel  | Signals                                          | Direction
//  ---------+--------------------------------------------------+----------
//  input    | in_valid, in_stall, command .. handle_in         | beat in
//  output   | out_valid, out_stall, status .. total_handles    | beat out
//  config   | cfg_write_enable, cfg_index, cfg_data            | write only
//
// One beat at a time: a new beat is accepted only once the last one's result is
// loaded. Steps: accept, scan over the slot memories, one slot a cycle, then update,
// a ring read for a successful get, and result load.
// The sweep, when due, is folded into the same scan.
// Reset clears slot valid bits, counters and the sweep time; no clearing pass.
// A finished result waits in the output register; the next beat is taken
// while it waits, and the sequencer holds only if a second result is ready.
module keyed_session_stack_cache #(
  parameter int unsigned KEY_SLOTS   = 16,
  parameter int unsigned RING_DEPTH  = 8,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  input  logic [31:0] now_seconds,
  input  logic [15:0] handle_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] handle_out,
  output logic [7:0]  total_handles
);
  localparam int unsigned IW  = $clog2(KEY_SLOTS);
  localparam int unsigned SCW = $clog2(KEY_SLOTS + 1);
  localparam int unsigned HW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned MW  = kssc_pkg::TIME_W + HW + FW;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_RING   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [31:0]   last_used;
    logic [HW-1:0] head;
    logic [FW-1:0] fill;
  } meta_t;

  state_t state;

  // Configuration
  logic [3:0]  max_per_key;
  logic [31:0] validity_seconds;
  logic [31:0] cleanup_delay_seconds;
  logic [31:0] next_sweep_time;

  // Latched item
  logic [1:0]             cmd;
  logic [127:0]           key;
  logic [31:0]            now;
  logic [HANDLE_BITS-1:0] handle;
  logic                   do_sweep;

  // Slot table
  logic [KEY_SLOTS-1:0] valid;
  logic [127:0]         key_mem  [KEY_SLOTS];
  logic [MW-1:0]        meta_mem [KEY_SLOTS];
  logic [127:0]         key_rd;
  meta_t                meta_rd;
  logic [IW-1:0]        rd_addr;
  logic                 key_we;
  logic                 meta_we;
  meta_t                meta_wd;

  // Scan
  logic [SCW-1:0] scan_cnt;
  logic           chk_valid;
  logic [IW-1:0]  chk_idx;
  logic           found;
  logic           free_found;
  logic [IW-1:0]  slot;
  logic [IW-1:0]  free_slot;
  meta_t          meta_cap;

  // Totals and results
  logic [7:0]  total;
  logic [1:0]  res_status;
  logic [15:0] res_handle;

  // Ring port
  logic [IW-1:0]          ring_slot;
  logic [HW-1:0]          ring_pos;
  logic                   ring_we;
  logic [HANDLE_BITS-1:0] ring_rdata;

  // Update-stage working values
  logic [IW-1:0]  upd_slot;
  meta_t          upd_meta;
  logic           upd_ok;
  logic [7:0]     limit;
  logic           drop;
  logic [HW-1:0]  head_inc;
  logic [HW-1:0]  head_dec;
  logic [32:0]    cutoff;
  logic           expire;
  logic           new_valid;

  assign in_stall = (state != S_IDLE);
  assign rd_addr  = scan_cnt[IW-1:0];

  // Clamp the per-key limit into 1 .. RING_DEPTH
  always_comb begin
    limit = 8'(max_per_key);
    if (limit == 8'd0) begin
      limit = 8'd1;
    end
    if (limit > 8'(RING_DEPTH)) begin
      limit = 8'(RING_DEPTH);
    end
  end

  // Sweep test on the slot read back this cycle
  assign cutoff    = {1'b0, now} + {1'b0, validity_seconds};
  assign expire    = ({1'b0, meta_rd.last_used} > cutoff) || (meta_rd.fill == '0);
  assign new_valid = valid[chk_idx] && !(do_sweep && expire);

  // Choose the slot and its state for the update stage
  always_comb begin
    upd_ok   = 1'b1;
    upd_slot = slot;
    upd_meta = meta_cap;
    if (!found) begin
      upd_slot = free_slot;
      upd_meta = '0;
      upd_ok   = free_found;
    end
  end

  assign drop     = (8'(upd_meta.fill) >= limit);
  assign head_inc = (32'(upd_meta.head) == RING_DEPTH - 1) ? '0 : upd_meta.head + 1'b1;
  assign head_dec = (upd_meta.head == '0) ? HW'(RING_DEPTH - 1) : upd_meta.head - 1'b1;

  // Memory writes and ring access
  always_comb begin
    key_we    = 1'b0;
    meta_we   = 1'b0;
    ring_we   = 1'b0;
    meta_wd   = upd_meta;
    ring_slot = upd_slot;
    ring_pos  = upd_meta.head;
    if (state == S_UPDATE) begin
      case (cmd)
        kssc_pkg::CMD_PUT: begin
          if (upd_ok) begin
            key_we         = !found;
            meta_we        = 1'b1;
            ring_we        = 1'b1;
            meta_wd.head   = head_inc;
            meta_wd.fill   = upd_meta.fill - FW'(drop) + 1'b1;
          end
        end
        kssc_pkg::CMD_GET: begin
          ring_pos = head_dec;
          if (found && meta_cap.fill != '0) begin
            meta_we           = 1'b1;
            meta_wd.last_used = now;
            meta_wd.head      = head_dec;
            meta_wd.fill      = meta_cap.fill - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Slot memories: registered read at the scan address
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[upd_slot] <= key;
    end
    if (meta_we) begin
      meta_mem[upd_slot] <= meta_wd;
    end
    key_rd  <= key_mem[rd_addr];
    meta_rd <= meta_mem[rd_addr];
  end

  kssc_handle_ring #(
    .KEY_SLOTS  (KEY_SLOTS),
    .RING_DEPTH (RING_DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_ring (
    .clk  (clk),
    .slot (ring_slot),
    .pos  (ring_pos),
    .we   (ring_we),
    .wdata(handle),
    .rdata(ring_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_per_key           <= 4'd8;
      validity_seconds      <= 32'd60;
      cleanup_delay_seconds <= 32'd60;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        kssc_pkg::CFG_MAX_PER_KEY:   max_per_key           <= cfg_data[3:0];
        kssc_pkg::CFG_VALIDITY:      validity_seconds      <= cfg_data;
        kssc_pkg::CFG_CLEANUP_DELAY: cleanup_delay_seconds <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Latch the input beat
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd    <= command;
      key    <= {key_high, key_low};
      now    <= now_seconds;
      handle <= HANDLE_BITS'(handle_in);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      valid           <= '0;
      total           <= '0;
      next_sweep_time <= '0;
      do_sweep        <= 1'b0;
      scan_cnt        <= '0;
      chk_valid       <= 1'b0;
      found           <= 1'b0;
      free_found      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      // Drop a taken result beat unless a new one is loaded this cycle
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            do_sweep   <= (command == kssc_pkg::CMD_PUT) &&
                          (next_sweep_time == '0 || now_seconds > next_sweep_time);
            if ((command == kssc_pkg::CMD_PUT) &&
                (next_sweep_time == '0 || now_seconds > next_sweep_time)) begin
              next_sweep_time <= now_seconds + cleanup_delay_seconds;
            end
            scan_cnt   <= '0;
            chk_valid  <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            res_status <= kssc_pkg::ST_OK;
            res_handle <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Check the slot read last cycle, issue the next read
          if (chk_valid) begin
            if (do_sweep && valid[chk_idx] && expire) begin
              valid[chk_idx] <= 1'b0;
              total          <= total - 8'(meta_rd.fill);
            end
            if (new_valid && key_rd == key && !found) begin
              found    <= 1'b1;
              slot     <= chk_idx;
              meta_cap <= meta_rd;
            end
            if (!new_valid && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= chk_idx;
            end
          end
          chk_valid <= (scan_cnt < SCW'(KEY_SLOTS));
          chk_idx   <= rd_addr;
          if (scan_cnt == SCW'(KEY_SLOTS)) begin
            state <= S_UPDATE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_UPDATE: begin
          state <= S_DONE;
          case (cmd)
            kssc_pkg::CMD_PUT: begin
              if (upd_ok) begin
                valid[upd_slot] <= 1'b1;
                total           <= total + 8'(!drop);
              end else begin
                res_status <= kssc_pkg::ST_TABLE_FULL;
              end
            end
            kssc_pkg::CMD_GET: begin
              if (found && meta_cap.fill != '0) begin
                total <= total - 8'd1;
                state <= S_RING;
              end else begin
                res_status <= kssc_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
        S_RING: begin
          res_handle <= 16'(ring_rdata);
          state      <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            handle_out    <= res_handle;
            total_handles <= total;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/kssc_handle_ring.sv -----
// Handle ring store: one ring of RING_DEPTH handles per key slot.
// Single write port, single registered read port. Uses no package items.
module kssc_handle_ring #(
  parameter int unsigned KEY_SLOTS   = 16,
  parameter int unsigned RING_DEPTH  = 8,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic [$clog2(KEY_SLOTS)-1:0]          slot,
  input  logic [((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1)-1:0] pos,
  input  logic                                  we,
  input  logic [HANDLE_BITS-1:0]                wdata,
  output logic [HANDLE_BITS-1:0]                rdata
);
  localparam int unsigned ENTRIES = KEY_SLOTS * RING_DEPTH;
  localparam int unsigned RAW     = $clog2(ENTRIES);

  logic [HANDLE_BITS-1:0] mem [ENTRIES];
  logic [RAW-1:0]         addr;

  // Flatten slot and ring position into one address
  assign addr = RAW'(slot) * RAW'(RING_DEPTH) + RAW'(pos);

  // Read one entry per cycle; write the same entry too when we is set
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- tb/sv/keyed_session_stack_cache_tb.sv -----
// Self-checking bench for keyed_session_stack_cache: directed and random beats,
// predicted by a behavioural copy of the slot table. Depends on kssc_pkg.
module keyed_session_stack_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int DEPTH = 8;

  typedef struct packed {
    logic [1:0]  st;
    logic [15:0] h;
    logic [7:0]  tot;
  } cache_reply_t;

  int error_count = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // Predicted cache state and expected replies
  class session_scoreboard;
    logic [3:0]  max_per_key = 8;
    logic [31:0] validity = 60, cleanup_delay = 60, next_sweep = 0;
    bit          ent_valid[SLOTS];
    logic [63:0] ent_kh[SLOTS], ent_kl[SLOTS];
    logic [31:0] ent_used[SLOTS];
    int          ent_head[SLOTS], ent_fill[SLOTS];
    logic [15:0] ring[SLOTS][DEPTH];
    cache_reply_t pending_replies[$];

    function int find_key(logic [63:0] kh, logic [63:0] kl);
      for (int i = 0; i < SLOTS; i++)
        if (ent_valid[i] && ent_kh[i] == kh && ent_kl[i] == kl) return i;
      return -1;
    endfunction

    // Apply one accepted beat and queue its reply
    function void note_beat(logic [1:0] cmd, logic [63:0] kh, logic [63:0] kl,
                            logic [31:0] now, logic [15:0] hin);
      cache_reply_t r;
      int s, lim, hp, sum;
      logic [32:0] cutoff;
      r = '0;
      if (cmd == kssc_pkg::CMD_PUT) begin
        if (next_sweep == 0 || now > next_sweep) begin
          cutoff = {1'b0, now} + {1'b0, validity};
          for (int i = 0; i < SLOTS; i++)
            if (ent_valid[i] && ({1'b0, ent_used[i]} > cutoff || ent_fill[i] == 0))
              ent_valid[i] = 0;
          next_sweep = now + cleanup_delay;
        end
        s = find_key(kh, kl);
        if (s < 0)
          for (int i = 0; i < SLOTS; i++)
            if (!ent_valid[i]) begin
              s = i;
              ent_valid[i] = 1; ent_kh[i] = kh; ent_kl[i] = kl;
              ent_used[i] = 0; ent_head[i] = 0; ent_fill[i] = 0;
              break;
            end
        if (s < 0) r.st = kssc_pkg::ST_TABLE_FULL;
        else begin
          lim = (max_per_key < 1) ? 1 : (max_per_key > DEPTH) ? DEPTH : max_per_key;
          if (ent_fill[s] >= lim) ent_fill[s]--;
          ring[s][ent_head[s]] = hin;
          ent_head[s] = (ent_head[s] + 1) % DEPTH;
          ent_fill[s]++;
        end
      end else if (cmd == kssc_pkg::CMD_GET) begin
        s = find_key(kh, kl);
        if (s < 0 || ent_fill[s] == 0) r.st = kssc_pkg::ST_NOT_FOUND;
        else begin
          hp = (ent_head[s] + DEPTH - 1) % DEPTH;
          ent_used[s] = now;
          r.h = ring[s][hp];
          ent_head[s] = hp;
          ent_fill[s]--;
        end
      end
      sum = 0;
      for (int i = 0; i < SLOTS; i++) if (ent_valid[i]) sum += ent_fill[i];
      r.tot = sum[7:0];
      pending_replies.push_back(r);
    endfunction

    task check_reply(cache_reply_t got);
      cache_reply_t w;
      if (pending_replies.size() == 0) begin
        report("reply with none expected");
        return;
      end
      w = pending_replies[0];
      pending_replies.delete(0);
      if (got.st !== w.st) report($sformatf("status %0d want %0d", got.st, w.st));
      if (got.h !== w.h) report($sformatf("handle %h want %h", got.h, w.h));
      if (got.tot !== w.tot) report($sformatf("total %0d want %0d", got.tot, w.tot));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic cfg_write_enable = 0;
  logic [1:0] cfg_index = kssc_pkg::CFG_MAX_PER_KEY;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [1:0] command = kssc_pkg::CMD_COUNT;
  logic [63:0] key_high = '0, key_low = '0;
  logic [31:0] now_seconds = '0;
  logic [15:0] handle_in = '0;
  logic [1:0] status;
  logic [15:0] handle_out;
  logic [7:0] total_handles;

  int send_idle_pct = 0, recv_idle_pct = 0;
  logic [31:0] clock_now = 1;
  logic [63:0] key_pool_h[6], key_pool_l[6];
  session_scoreboard board = new();

  keyed_session_stack_cache uut (.*);

  initial forever #5 clk = ~clk;

  // Hard stop
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stall, check each reply beat
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_reply('{status, handle_out, total_handles});
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Write one register, then pause with the write enable low
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_write_enable <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write_enable <= 0;
    if (idx == kssc_pkg::CFG_MAX_PER_KEY) board.max_per_key = val[3:0];
    else if (idx == kssc_pkg::CFG_VALIDITY) board.validity = val;
    else board.cleanup_delay = val;
    @(posedge clk);
  endtask

  // Drive one beat and hold it until taken
  task automatic send_beat(logic [1:0] cmd, logic [63:0] kh, logic [63:0] kl,
                           logic [31:0] now, logic [15:0] hin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; command <= cmd; key_high <= kh; key_low <= kl;
    now_seconds <= now; handle_in <= hin;
    do @(posedge clk); while (in_stall);
    board.note_beat(cmd, kh, kl, now, hin);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Mostly pooled keys with drifting time; some fresh keys and time jumps
  task automatic random_beat();
    int k;
    logic [1:0] cmd;
    k = $urandom_range(5);
    if ($urandom_range(9) < 5) cmd = kssc_pkg::CMD_PUT;
    else if ($urandom_range(4) == 0)
      cmd = ($urandom_range(1) == 0) ? kssc_pkg::CMD_COUNT : kssc_pkg::CMD_SPARE;
    else cmd = kssc_pkg::CMD_GET;
    if ($urandom_range(19) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(20);
    if ($urandom_range(9) == 0)
      send_beat(cmd, {$urandom, $urandom}, {$urandom, $urandom}, clock_now,
                16'($urandom));
    else
      send_beat(cmd, key_pool_h[k], key_pool_l[k], clock_now, 16'($urandom));
  endtask

  initial begin
    for (int i = 0; i < 6; i++) begin
      key_pool_h[i] = {$urandom, $urandom};
      key_pool_l[i] = {$urandom, $urandom};
    end
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extreme keys, handles, overflow of one ring, table full
    send_idle_pct = 16; recv_idle_pct = 60;
    send_beat(kssc_pkg::CMD_GET, '0, '0, 0, 0);
    send_beat(kssc_pkg::CMD_PUT, '0, '0, 0, 16'hffff);
    send_beat(kssc_pkg::CMD_PUT, '1, '1, 32'hffffffff, 16'h0000);
    send_beat(kssc_pkg::CMD_GET, '1, '1, 32'hffffffff, 0);
    send_beat(kssc_pkg::CMD_GET, '1, '1, 5, 0);
    for (int i = 0; i < 10; i++) send_beat(kssc_pkg::CMD_PUT, 64'h5, 64'ha, 1, 16'(i));
    send_beat(kssc_pkg::CMD_GET, 64'h5, 64'ha, 2, 0);
    for (int i = 0; i < 17; i++)
      send_beat(kssc_pkg::CMD_PUT, 64'(i), 64'h77, 3, 16'(i));
    send_beat(kssc_pkg::CMD_COUNT, 0, 0, 3, 0);
    send_beat(kssc_pkg::CMD_SPARE, 0, 0, 3, 0);
    drain();

    // Small limit, cutoff overflow, zero delay
    write_reg(kssc_pkg::CFG_MAX_PER_KEY, 0);
    write_reg(kssc_pkg::CFG_VALIDITY, 32'hffffffff);
    write_reg(kssc_pkg::CFG_CLEANUP_DELAY, 0);
    for (int i = 0; i < 350; i++) random_beat();
    drain();

    // Limit above ring depth, no validity window
    send_idle_pct = 60; recv_idle_pct = 16;
    write_reg(kssc_pkg::CFG_MAX_PER_KEY, 32'hf);
    write_reg(kssc_pkg::CFG_VALIDITY, 0);
    write_reg(kssc_pkg::CFG_CLEANUP_DELAY, 32'hffffffff);
    for (int i = 0; i < 350; i++) random_beat();
    drain();

    // Middle settings, no idling
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(kssc_pkg::CFG_MAX_PER_KEY, 3);
    write_reg(kssc_pkg::CFG_VALIDITY, 10);
    write_reg(kssc_pkg::CFG_CLEANUP_DELAY, 15);
    for (int i = 0; i < 370; i++) random_beat();
    drain();

    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/kssc_pkg.sv
rtl/core/kssc_handle_ring.sv
rtl/core/keyed_session_stack_cache.sv
tb/sv/keyed_session_stack_cache_tb.sv
